// ----- sv/spa_pkg.sv -----
package spa_pkg;

  localparam int unsigned SpaDepth = 32;
  localparam int unsigned ExpW     = 16;
  localparam int unsigned CoefW    = 32;
  localparam int unsigned TermW    = ExpW + CoefW;

  localparam logic [1:0] ModeLoadFirst  = 2'd0;
  localparam logic [1:0] ModeLoadSecond = 2'd1;
  localparam logic [1:0] ModeMerge      = 2'd2;

  typedef logic signed [ExpW-1:0]  exp_t;
  typedef logic signed [CoefW-1:0] coef_t;

  typedef struct packed {
    logic load_first;
    logic load_second;
    logic start;
    logic advance;
  } spa_cmd_t;

  typedef struct packed {
    logic last;
  } spa_sts_t;

endpackage

// ----- sv/spa_in_if.sv -----
interface spa_in_if
  import spa_pkg::*;
();
  logic       valid;
  logic       ready;
  logic [1:0] mode;
  exp_t       exponent;
  coef_t      coefficient;

  modport source (output valid, output mode, output exponent, output coefficient,
                  input ready);
  modport sink (input valid, input mode, input exponent, input coefficient,
                output ready);
endinterface

// ----- sv/spa_out_if.sv -----
interface spa_out_if
  import spa_pkg::*;
();
  logic  valid;
  logic  ready;
  exp_t  term_exponent;
  coef_t term_coefficient;
  logic  last;
  logic  empty_res;
  logic  dropped;

  modport source (output valid, output term_exponent, output term_coefficient,
                  output last, output empty_res, output dropped, input ready);
  modport sink (input valid, input term_exponent, input term_coefficient,
                input last, input empty_res, input dropped, output ready);
endinterface

// ----- sv/sparse_polynomial_add.sv -----
// Sparse polynomial adder over two term buffers of DEPTH entries each.
// Loads are taken only while no merge is being emitted; the block then accepts one term per cycle.
// A merge transfer is followed in the next cycle by its first result term, then
// one result term per cycle while the sink is ready, up to 2*DEPTH terms.
// Reset (asynchronous, active low) empties both buffers and clears the drop flag.
module sparse_polynomial_add
  import spa_pkg::*;
#(
  parameter int unsigned DEPTH = SpaDepth
) (
  input  logic clk_i,
  input  logic rst_ni,
  spa_in_if.sink    in_i,
  spa_out_if.source out_o
);

  spa_cmd_t cmd;
  spa_sts_t sts;

  spa_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_mode_i   (in_i.mode),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  spa_dp #(.DEPTH(DEPTH)) u_dp (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cmd_i              (cmd),
    .sts_o              (sts),
    .exponent_i         (in_i.exponent),
    .coefficient_i      (in_i.coefficient),
    .term_exponent_o    (out_o.term_exponent),
    .term_coefficient_o (out_o.term_coefficient),
    .last_o             (out_o.last),
    .empty_res_o        (out_o.empty_res),
    .dropped_o          (out_o.dropped)
  );

endmodule

// ----- sv/spa_ram.sv -----
module spa_ram #(
  parameter int unsigned Width = 48,
  parameter int unsigned Depth = 32,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- sv/spa_ctrl.sv -----
module spa_ctrl
  import spa_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic [1:0] in_mode_i,
  output logic       in_ready_o,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  input  spa_sts_t   sts_i,
  output spa_cmd_t   cmd_o
);

  localparam logic StIdle = 1'b0;
  localparam logic StEmit = 1'b1;

  logic state_q, state_d;
  logic in_xfer, out_xfer;

  assign in_ready_o  = (state_q == StIdle);
  assign out_valid_o = (state_q == StEmit);
  assign in_xfer     = in_valid_i && in_ready_o;
  assign out_xfer    = out_valid_o && out_ready_i;

  always_comb begin
    cmd_o.load_first  = in_xfer && (in_mode_i == ModeLoadFirst);
    cmd_o.load_second = in_xfer && (in_mode_i == ModeLoadSecond);
    cmd_o.start       = in_xfer && (in_mode_i == ModeMerge);
    cmd_o.advance     = out_xfer;
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle: begin
        if (cmd_o.start) begin
          state_d = StEmit;
        end
      end
      StEmit: begin
        if (out_xfer && sts_i.last) begin
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ----- sv/spa_dp.sv -----
module spa_dp
  import spa_pkg::*;
#(
  parameter int unsigned DEPTH = SpaDepth
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  spa_cmd_t cmd_i,
  output spa_sts_t sts_o,
  input  exp_t     exponent_i,
  input  coef_t    coefficient_i,
  output exp_t     term_exponent_o,
  output coef_t    term_coefficient_o,
  output logic     last_o,
  output logic     empty_res_o,
  output logic     dropped_o
);

  localparam int unsigned AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW  = $clog2(DEPTH + 1);

  logic [CntW-1:0] cnt_a_q, cnt_b_q, i_q, j_q, i_d, j_d, i_nxt, j_nxt;
  logic            lost_q, drop_q, empty_q;
  logic            full_a, full_b, we_a, we_b;
  logic [TermW-1:0] rdata_a, rdata_b;
  exp_t            ea, eb, res_e;
  coef_t           ca, cb, res_c, sum_sat;
  logic signed [CoefW:0] sum;
  logic            a_ok, b_ok, take_a, take_b, last_n, is_last;

  assign full_a = (cnt_a_q == CntW'(DEPTH));
  assign full_b = (cnt_b_q == CntW'(DEPTH));
  assign we_a   = cmd_i.load_first && !full_a;
  assign we_b   = cmd_i.load_second && !full_b;

  spa_ram #(.Width(TermW), .Depth(DEPTH)) u_ram_a (
    .clk_i   (clk_i),
    .we_i    (we_a),
    .waddr_i (cnt_a_q[AddrW-1:0]),
    .wdata_i ({exponent_i, coefficient_i}),
    .raddr_i (i_d[AddrW-1:0]),
    .rdata_o (rdata_a)
  );

  spa_ram #(.Width(TermW), .Depth(DEPTH)) u_ram_b (
    .clk_i   (clk_i),
    .we_i    (we_b),
    .waddr_i (cnt_b_q[AddrW-1:0]),
    .wdata_i ({exponent_i, coefficient_i}),
    .raddr_i (j_d[AddrW-1:0]),
    .rdata_o (rdata_b)
  );

  assign ea = rdata_a[TermW-1:CoefW];
  assign ca = rdata_a[CoefW-1:0];
  assign eb = rdata_b[TermW-1:CoefW];
  assign cb = rdata_b[CoefW-1:0];

  assign a_ok = (i_q < cnt_a_q);
  assign b_ok = (j_q < cnt_b_q);

  assign sum = {ca[CoefW-1], ca} + {cb[CoefW-1], cb};
  always_comb begin
    if (sum[CoefW] != sum[CoefW-1]) begin
      sum_sat = sum[CoefW] ? {1'b1, {(CoefW-1){1'b0}}} : {1'b0, {(CoefW-1){1'b1}}};
    end else begin
      sum_sat = sum[CoefW-1:0];
    end
  end

  always_comb begin
    take_a = 1'b0;
    take_b = 1'b0;
    res_e  = eb;
    res_c  = cb;
    priority if (a_ok && b_ok) begin
      if (ea == eb) begin
        take_a = 1'b1;
        take_b = 1'b1;
        res_e  = ea;
        res_c  = sum_sat;
      end else if (ea > eb) begin
        take_a = 1'b1;
        res_e  = ea;
        res_c  = ca;
      end else begin
        take_b = 1'b1;
      end
    end else if (a_ok) begin
      take_a = 1'b1;
      res_e  = ea;
      res_c  = ca;
    end else begin
      take_b = b_ok;
    end
  end

  assign i_nxt   = i_q + CntW'(take_a);
  assign j_nxt   = j_q + CntW'(take_b);
  assign last_n  = (i_nxt >= cnt_a_q) && (j_nxt >= cnt_b_q);
  assign is_last = empty_q || last_n;

  always_comb begin
    i_d = i_q;
    j_d = j_q;
    if (cmd_i.advance) begin
      if (is_last) begin
        i_d = '0;
        j_d = '0;
      end else begin
        i_d = i_nxt;
        j_d = j_nxt;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_a_q <= '0;
      cnt_b_q <= '0;
      lost_q  <= 1'b0;
      drop_q  <= 1'b0;
      empty_q <= 1'b0;
      i_q     <= '0;
      j_q     <= '0;
    end else begin
      i_q <= i_d;
      j_q <= j_d;
      if (we_a) begin
        cnt_a_q <= cnt_a_q + CntW'(1);
      end
      if (we_b) begin
        cnt_b_q <= cnt_b_q + CntW'(1);
      end
      if ((cmd_i.load_first && full_a) || (cmd_i.load_second && full_b)) begin
        lost_q <= 1'b1;
      end
      if (cmd_i.start) begin
        drop_q  <= lost_q;
        empty_q <= (cnt_a_q == '0) && (cnt_b_q == '0);
      end
      if (cmd_i.advance && is_last) begin
        cnt_a_q <= '0;
        cnt_b_q <= '0;
        lost_q  <= 1'b0;
      end
    end
  end

  assign sts_o.last  = is_last;

  assign term_exponent_o    = empty_q ? '0 : res_e;
  assign term_coefficient_o = empty_q ? '0 : res_c;
  assign last_o             = is_last;
  assign empty_res_o        = empty_q;
  assign dropped_o          = drop_q;

endmodule
